// ----- hw/rtl/handle_table_with_fifo_id_recycling_assert.svh -----
// Assertion macros shared by the handle table modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef HANDLE_TABLE_WITH_FIFO_ID_RECYCLING_ASSERT_SVH
`define HANDLE_TABLE_WITH_FIFO_ID_RECYCLING_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTFR_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HTFR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/htfr_pkg.sv -----
package htfr_pkg;

    // Field widths of the request and response transfers.
    localparam int CMD_W  = 2;
    localparam int SID_W  = 16;
    localparam int HIN_W  = 32;
    localparam int AID_W  = 8;
    localparam int HOUT_W = 32;

    localparam int DEF_CAPACITY    = 256;
    localparam int DEF_HANDLE_BITS = 32;

    typedef enum logic [CMD_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_ACCESS  = 2'd1,
        OP_DESTROY = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RS_OK    = 2'd0,
        RS_FULL  = 2'd1,
        RS_RANGE = 2'd2,
        RS_EMPTY = 2'd3
    } rs_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic execute;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_room;
    } ctl_stat_t;

endpackage

// ----- hw/rtl/htfr_req_if.sv -----
interface htfr_req_if;
    logic                       valid;
    logic                       ready;
    logic [htfr_pkg::CMD_W-1:0] cmd;
    logic [htfr_pkg::SID_W-1:0] slot_id;
    logic [htfr_pkg::HIN_W-1:0] handle_in;

    modport source (output valid, output cmd, output slot_id, output handle_in, input ready);
    modport sink (input valid, input cmd, input slot_id, input handle_in, output ready);
endinterface

// ----- hw/rtl/htfr_rsp_if.sv -----
interface htfr_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [htfr_pkg::AID_W-1:0]  assigned_id;
    logic [htfr_pkg::HOUT_W-1:0] handle_out;
    logic                        hit;
    logic [1:0]                  status;

    modport source (output valid, output assigned_id, output handle_out, output hit,
                    output status, input ready);
    modport sink (input valid, input assigned_id, input handle_out, input hit,
                  input status, output ready);
endinterface

// ----- hw/rtl/handle_table_with_fifo_id_recycling.sv -----
// Handle table with FIFO id recycling. Each request transfer on req carries an
// insert, access, destroy or no-op command and yields exactly one response
// transfer on rsp, in order. An insert stores handle_in and returns an id: the
// oldest id freed by a destroy if any are queued, otherwise the live count; a
// full table answers with the full status. Access returns the stored handle,
// destroy frees the slot; both report out-of-range and empty-slot cases. After
// reset the block sweeps the slot memory to clear the occupied flags, one entry
// per cycle, so req.ready stays low during the sweep. After that the accepting
// cycle of each command reads the slot memory and the head of the free-id FIFO
// into registers, and the execute step decides, writes both memories and
// loads the response register. That register lets a result wait for rsp.ready
// while the next request transfer is already accepted; a command whose result
// cannot be loaded waits until the pending one is taken.

module handle_table_with_fifo_id_recycling #(
    parameter int CAPACITY    = htfr_pkg::DEF_CAPACITY,
    parameter int HANDLE_BITS = htfr_pkg::DEF_HANDLE_BITS
) (
    input logic       clk,
    input logic       rst_n,
    htfr_req_if.sink  req,
    htfr_rsp_if.source rsp
);

    // Command and status between the sequencer and the table datapath.
    htfr_pkg::ctl_cmd_t  ctl_cmd;
    htfr_pkg::ctl_stat_t ctl_stat;

    // The sequencer owns the request handshake: ready only while idle.
    htfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (ctl_stat),
        .cmd       (ctl_cmd)
    );

    // The datapath holds the slot memory, the free-id FIFO, the counters and
    // the response register.
    htfr_dpath #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (ctl_cmd),
        .stat            (ctl_stat),
        .req_cmd         (req.cmd),
        .req_slot_id     (req.slot_id),
        .req_handle_in   (req.handle_in),
        .rsp_valid       (rsp.valid),
        .rsp_ready       (rsp.ready),
        .rsp_assigned_id (rsp.assigned_id),
        .rsp_handle_out  (rsp.handle_out),
        .rsp_hit         (rsp.hit),
        .rsp_status      (rsp.status)
    );

endmodule

// ----- hw/rtl/htfr_ctrl.sv -----
`include "handle_table_with_fifo_id_recycling_assert.svh"

module htfr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  htfr_pkg::ctl_stat_t stat,
    output htfr_pkg::ctl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } ctl_state_t;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_comb
    begin
        state_next     = state_reg;
        req_ready      = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.capture    = 1'b0;
        cmd.execute    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // Wait here until the response register can take the result.
                if (stat.out_room)
                begin
                    cmd.execute = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `HTFR_ASSERT_NEXT(a_capture_to_exec, cmd.capture, state_reg == ST_EXEC,
                      "capture did not lead to execute state")
    `HTFR_ASSERT_NEXT(a_execute_to_idle, cmd.execute, state_reg == ST_IDLE,
                      "execute did not return to idle")
    `HTFR_ASSERT_NEXT(a_exec_holds, (state_reg == ST_EXEC) && !stat.out_room,
                      state_reg == ST_EXEC, "left execute state without room for result")

endmodule

// ----- hw/rtl/htfr_dpath.sv -----
`include "handle_table_with_fifo_id_recycling_assert.svh"

module htfr_dpath #(
    parameter int CAPACITY    = htfr_pkg::DEF_CAPACITY,
    parameter int HANDLE_BITS = htfr_pkg::DEF_HANDLE_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  htfr_pkg::ctl_cmd_t          cmd,
    output htfr_pkg::ctl_stat_t         stat,
    input  logic [htfr_pkg::CMD_W-1:0]  req_cmd,
    input  logic [htfr_pkg::SID_W-1:0]  req_slot_id,
    input  logic [htfr_pkg::HIN_W-1:0]  req_handle_in,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [htfr_pkg::AID_W-1:0]  rsp_assigned_id,
    output logic [htfr_pkg::HOUT_W-1:0] rsp_handle_out,
    output logic                        rsp_hit,
    output logic [1:0]                  rsp_status
);

    localparam int ID_BITS    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int STORE_BITS = (HANDLE_BITS < htfr_pkg::HIN_W) ? HANDLE_BITS
                                                                : htfr_pkg::HIN_W;
    localparam logic [ID_BITS-1:0]          LAST_IDX  = ID_BITS'(CAPACITY - 1);
    localparam logic [CNT_BITS-1:0]         CNT_CAP   = CNT_BITS'(CAPACITY);
    localparam logic [CNT_BITS:0]           SUM_LIMIT = (CNT_BITS + 1)'(CAPACITY);
    localparam logic [htfr_pkg::SID_W:0]    SID_LIMIT = (htfr_pkg::SID_W + 1)'(CAPACITY);

    // Slot memory word: occupied flag on top of the stored handle.
    logic [STORE_BITS:0]   slot_mem [CAPACITY];
    logic [ID_BITS-1:0]    fifo_mem [CAPACITY];

    logic [STORE_BITS:0]   slot_rd_reg;
    logic [ID_BITS-1:0]    fifo_rd_reg;

    htfr_pkg::op_t         op_reg;
    logic [htfr_pkg::SID_W-1:0] sid_reg;
    logic [STORE_BITS-1:0] hnd_reg;

    logic [ID_BITS-1:0]    clr_idx_reg;
    logic [ID_BITS-1:0]    head_reg, head_next;
    logic [ID_BITS-1:0]    tail_reg, tail_next;
    logic [CNT_BITS-1:0]   fill_reg, fill_next;
    logic [CNT_BITS-1:0]   live_reg, live_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    logic [htfr_pkg::AID_W-1:0]  aid_reg, aid_next;
    logic [htfr_pkg::HOUT_W-1:0] hout_reg, hout_next;
    logic                  hit_reg, hit_next;
    htfr_pkg::rs_t         status_reg, status_next;

    logic                  slot_we;
    logic [ID_BITS-1:0]    slot_waddr;
    logic [STORE_BITS:0]   slot_wdata;
    logic                  fifo_we;

    logic [ID_BITS-1:0]    sid_idx;
    logic [ID_BITS-1:0]    new_id;
    logic [15:0]           new_id16;
    logic                  in_range;
    logic                  occ;

    assign sid_idx  = sid_reg[ID_BITS-1:0];
    assign in_range = {1'b0, sid_reg} < SID_LIMIT;
    assign occ      = slot_rd_reg[STORE_BITS];
    assign new_id   = (fill_reg != '0) ? fifo_rd_reg : live_reg[ID_BITS-1:0];
    assign new_id16 = 16'(new_id);

    assign stat.clear_last = (clr_idx_reg == LAST_IDX);
    assign stat.out_room   = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        live_next   = live_reg;
        aid_next    = '0;
        hout_next   = '0;
        hit_next    = 1'b0;
        status_next = htfr_pkg::RS_OK;
        slot_we     = 1'b0;
        slot_waddr  = sid_idx;
        slot_wdata  = '0;
        fifo_we     = 1'b0;
        if (cmd.clear_step)
        begin
            slot_we    = 1'b1;
            slot_waddr = clr_idx_reg;
        end
        else if (cmd.execute)
        begin
            unique case (op_reg)
                htfr_pkg::OP_INSERT:
                begin
                    if (live_reg == CNT_CAP)
                    begin
                        status_next = htfr_pkg::RS_FULL;
                    end
                    else
                    begin
                        if (fill_reg != '0)
                        begin
                            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                            fill_next = fill_reg - 1'b1;
                        end
                        live_next  = live_reg + 1'b1;
                        slot_we    = 1'b1;
                        slot_waddr = new_id;
                        slot_wdata = {1'b1, hnd_reg};
                        aid_next   = new_id16[htfr_pkg::AID_W-1:0];
                    end
                end
                htfr_pkg::OP_ACCESS, htfr_pkg::OP_DESTROY:
                begin
                    if (!in_range)
                    begin
                        status_next = htfr_pkg::RS_RANGE;
                    end
                    else if (!occ)
                    begin
                        status_next = htfr_pkg::RS_EMPTY;
                    end
                    else if (op_reg == htfr_pkg::OP_ACCESS)
                    begin
                        hit_next  = 1'b1;
                        hout_next = htfr_pkg::HOUT_W'(slot_rd_reg[STORE_BITS-1:0]);
                    end
                    else
                    begin
                        hit_next = 1'b1;
                        slot_we  = 1'b1;
                        if (live_reg != '0)
                        begin
                            live_next = live_reg - 1'b1;
                        end
                        if (fill_reg != CNT_CAP)
                        begin
                            fifo_we   = 1'b1;
                            tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                end
                htfr_pkg::OP_NOP:
                begin
                    status_next = htfr_pkg::RS_OK;
                end
                default:
                begin
                    status_next = htfr_pkg::RS_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.execute)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Memories: registered reads at capture, writes from the execute step or the clear sweep.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_rd_reg <= slot_mem[req_slot_id[ID_BITS-1:0]];
            fifo_rd_reg <= fifo_mem[head_reg];
        end
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (fifo_we)
        begin
            fifo_mem[tail_reg] <= sid_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= htfr_pkg::op_t'(req_cmd);
            sid_reg <= req_slot_id;
            hnd_reg <= req_handle_in[STORE_BITS-1:0];
        end
        if (cmd.execute)
        begin
            aid_reg    <= aid_next;
            hout_reg   <= hout_next;
            hit_reg    <= hit_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            live_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            live_reg      <= live_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign rsp_assigned_id = aid_reg;
    assign rsp_handle_out  = hout_reg;
    assign rsp_hit         = hit_reg;
    assign rsp_status      = status_reg;

    `HTFR_ASSERT_NOW(a_id_budget, 1'b1, ({1'b0, live_reg} + {1'b0, fill_reg}) <= SUM_LIMIT,
                     "live and queued ids exceed capacity")
    `HTFR_ASSERT_NOW(a_fifo_empty_ptrs, fill_reg == '0, head_reg == tail_reg,
                     "empty free list with unequal pointers")
    `HTFR_ASSERT_NEXT(a_result_loaded, cmd.execute, rsp_valid_reg,
                      "executed command left no result")

endmodule

// ----- bench/handle_table_with_fifo_id_recycling_tb.sv -----
// Self-checking bench for the handle table. A stimulus process offers request
// transfers, keeps its own image of the table and queues the response that each
// accepted request must produce; a monitor checks every response transfer
// against the oldest queued one.
module handle_table_with_fifo_id_recycling_tb;

    import htfr_pkg::*;

    localparam int SLOTS        = DEF_CAPACITY;
    localparam int SLOT_BITS    = $clog2(SLOTS);
    localparam int RANDOM_ITEMS = 1350;

    // One response as the table is expected to return it.
    typedef struct packed {
        logic [AID_W-1:0]  aid;
        logic [HOUT_W-1:0] hout;
        logic              hit;
        rs_t               st;
    } table_rsp_t;

    // One row of the directed stimulus. When known is set, want holds the
    // response typed in by hand; otherwise the table image supplies it.
    typedef struct packed {
        op_t              op;
        logic [SID_W-1:0] sid;
        logic [HIN_W-1:0] hdl;
        logic             known;
        table_rsp_t       want;
    } dir_row_t;

    localparam int DIR_ROWS = 21;

    logic clk;
    logic rst_n;

    htfr_req_if req_ch ();
    htfr_rsp_if rsp_ch ();

    handle_table_with_fifo_id_recycling u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Image of the table: stored handles, occupancy, freed ids and live count.
    logic [HIN_W-1:0] tbl_handle [SLOTS];
    bit               tbl_used   [SLOTS];
    bit [7:0]         freed_ids  [$];
    int               live_cnt;

    // Responses owed by the table, oldest first.
    table_rsp_t table_rsp_q [$];

    int mismatch_cnt;
    int sent_cnt;
    int send_idle_pct;
    int recv_idle_pct;

    // The directed rows start from the state after reset. The first rows hit
    // the empty and out-of-range cases and the unused command, then two
    // inserts store the largest handle and a zero handle, which must still
    // count as an occupant. A destroy, a second destroy of the same slot and a
    // recycling insert follow.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{OP_ACCESS,  16'd0,     32'h0000_0000, 1'b1, '{8'd0, 32'h0, 1'b0, RS_EMPTY}},
        '{OP_DESTROY, 16'd0,     32'hFFFF_FFFF, 1'b1, '{8'd0, 32'h0, 1'b0, RS_EMPTY}},
        '{OP_ACCESS,  16'd255,   32'h0000_0000, 1'b1, '{8'd0, 32'h0, 1'b0, RS_EMPTY}},
        '{OP_ACCESS,  16'hFFFF,  32'h0000_0000, 1'b1, '{8'd0, 32'h0, 1'b0, RS_RANGE}},
        '{OP_DESTROY, 16'd256,   32'h0000_0000, 1'b1, '{8'd0, 32'h0, 1'b0, RS_RANGE}},
        '{OP_NOP,     16'hFFFF,  32'hFFFF_FFFF, 1'b1, '{8'd0, 32'h0, 1'b0, RS_OK}},
        '{OP_INSERT,  16'hFFFF,  32'hFFFF_FFFF, 1'b1, '{8'd0, 32'h0, 1'b0, RS_OK}},
        '{OP_INSERT,  16'd0,     32'h0000_0000, 1'b1, '{8'd1, 32'h0, 1'b0, RS_OK}},
        '{OP_ACCESS,  16'd0,     32'h0000_0000, 1'b1,
          '{8'd0, 32'hFFFF_FFFF, 1'b1, RS_OK}},
        '{OP_ACCESS,  16'd1,     32'hFFFF_FFFF, 1'b1, '{8'd0, 32'h0, 1'b1, RS_OK}},
        '{OP_DESTROY, 16'd0,     32'h0000_0000, 1'b1, '{8'd0, 32'h0, 1'b1, RS_OK}},
        '{OP_ACCESS,  16'd0,     32'h0000_0000, 1'b1, '{8'd0, 32'h0, 1'b0, RS_EMPTY}},
        '{OP_DESTROY, 16'd0,     32'h0000_0000, 1'b1, '{8'd0, 32'h0, 1'b0, RS_EMPTY}},
        '{OP_INSERT,  16'd7,     32'h1234_5678, 1'b0, '0},
        '{OP_DESTROY, 16'd1,     32'h0000_0000, 1'b0, '0},
        '{OP_INSERT,  16'd0,     32'hDEAD_BEEF, 1'b0, '0},
        '{OP_ACCESS,  16'hFF00,  32'h0000_0000, 1'b1, '{8'd0, 32'h0, 1'b0, RS_RANGE}},
        '{OP_DESTROY, 16'd255,   32'h0000_0000, 1'b1, '{8'd0, 32'h0, 1'b0, RS_EMPTY}},
        '{OP_ACCESS,  16'd0,     32'h0000_0000, 1'b0, '0},
        '{OP_NOP,     16'd0,     32'h0000_0000, 1'b1, '{8'd0, 32'h0, 1'b0, RS_OK}},
        '{OP_ACCESS,  16'd256,   32'h0000_0000, 1'b1, '{8'd0, 32'h0, 1'b0, RS_RANGE}}
    };

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Applies one command to the table image and returns the response the
    // block owes for it.
    function automatic table_rsp_t table_step(op_t op, logic [SID_W-1:0] sid,
                                              logic [HIN_W-1:0] hdl);
        table_rsp_t           r;
        logic [SLOT_BITS-1:0] id;
        r = '{aid: '0, hout: '0, hit: 1'b0, st: RS_OK};
        case (op)
            OP_INSERT:
            begin
                if (live_cnt >= SLOTS)
                begin
                    r.st = RS_FULL;
                end
                else
                begin
                    // Freed ids are handed out oldest first; with none queued
                    // the live count names the next fresh slot.
                    if (freed_ids.size() > 0)
                        id = freed_ids.pop_front();
                    else
                        id = live_cnt[SLOT_BITS-1:0];
                    live_cnt++;
                    tbl_handle[id] = hdl;
                    tbl_used[id]   = 1'b1;
                    r.aid = AID_W'(id);
                end
            end
            OP_NOP:
            begin
            end
            default:
            begin
                if (sid >= SLOTS)
                begin
                    r.st = RS_RANGE;
                end
                else if (!tbl_used[sid[SLOT_BITS-1:0]])
                begin
                    r.st = RS_EMPTY;
                end
                else if (op == OP_ACCESS)
                begin
                    r.hout = tbl_handle[sid[SLOT_BITS-1:0]];
                    r.hit  = 1'b1;
                end
                else
                begin
                    tbl_used[sid[SLOT_BITS-1:0]]   = 1'b0;
                    tbl_handle[sid[SLOT_BITS-1:0]] = '0;
                    if (live_cnt > 0)
                        live_cnt--;
                    if (freed_ids.size() < SLOTS)
                        freed_ids.push_back(sid[7:0]);
                    r.hit = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    // Returns a random occupied slot. Only called while the table holds at
    // least one handle.
    function automatic int any_used_id();
        int k;
        k = $urandom_range(SLOTS - 1);
        while (!tbl_used[k[SLOT_BITS-1:0]])
            k = $urandom_range(SLOTS - 1);
        return k;
    endfunction

    // Offers one request transfer, holding valid high until the block takes
    // it. Idle cycles may be inserted before the request goes up. Once the
    // transfer happens, the owed response is queued: the hand-typed one when
    // the caller supplies it, otherwise the one from the table image.
    task automatic issue_cmd(op_t op, logic [SID_W-1:0] sid, logic [HIN_W-1:0] hdl,
                             logic known, table_rsp_t want);
        table_rsp_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= op;
        req_ch.slot_id   <= sid;
        req_ch.handle_in <= hdl;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = table_step(op, sid, hdl);
        table_rsp_q.push_back(known ? want : predicted);
        sent_cnt++;
    endtask

    // Shorthand for a random-part command checked against the table image.
    task automatic issue_rand(op_t op, int sid);
        issue_cmd(op, SID_W'(sid), $urandom, 1'b0, '0);
    endtask

    // The receiver drops ready at random, at the rate of the current phase.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every response transfer is checked against the oldest owed response.
    // Fields are reported as id/handle/hit/status.
    always @(posedge clk)
    begin
        table_rsp_t got;
        table_rsp_t w;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = '{aid: rsp_ch.assigned_id, hout: rsp_ch.handle_out,
                    hit: rsp_ch.hit, st: rs_t'(rsp_ch.status)};
            if (table_rsp_q.size() == 0)
            begin
                mismatch_cnt++;
                $display("%0t: unexpected response, expected none, actual %0d/%h/%0d/%0d",
                         $time, got.aid, got.hout, got.hit, got.st);
            end
            else
            begin
                w = table_rsp_q.pop_front();
                if (got !== w)
                begin
                    mismatch_cnt++;
                    $display("%0t: mismatch, expected %0d/%h/%0d/%0d, actual %0d/%h/%0d/%0d",
                             $time, w.aid, w.hout, w.hit, w.st,
                             got.aid, got.hout, got.hit, got.st);
                end
            end
        end
    end

    // Stimulus: reset, the directed rows, then random episodes. Each episode
    // is a well-formed sequence with random content, except the noise one.
    initial
    begin
        int kind;
        int n;
        int pick;
        op_t op;

        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.cmd       = OP_NOP;
        req_ch.slot_id   = '0;
        req_ch.handle_in = '0;
        mismatch_cnt     = 0;
        sent_cnt         = 0;
        live_cnt         = 0;
        send_idle_pct    = 23;
        recv_idle_pct    = 48;
        tbl_handle       = '{default: '0};
        tbl_used         = '{default: 1'b0};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The block sweeps its slot memory after reset; the handshake simply
        // waits for ready to come up.
        for (int i = 0; i < DIR_ROWS; i++)
            issue_cmd(dir_rows[i].op, dir_rows[i].sid, dir_rows[i].hdl,
                      dir_rows[i].known, dir_rows[i].want);

        // The first episode always fills the table so the full status is seen.
        kind = 0;
        while (sent_cnt < RANDOM_ITEMS + DIR_ROWS)
        begin
            // Idle rates move through three phases: sender light and receiver
            // heavy, then swapped, then no idling at all.
            if (sent_cnt < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 23;
                recv_idle_pct = 48;
            end
            else if (sent_cnt < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 23;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case (kind)
                0:
                begin
                    // Fill to capacity, then push against the full table.
                    while (live_cnt < SLOTS)
                        issue_rand(OP_INSERT, $urandom_range(65535));
                    repeat ($urandom_range(1, 4))
                        issue_rand(OP_INSERT, $urandom_range(65535));
                end
                1:
                begin
                    // Drain occupied slots in random order; sometimes all of
                    // them, which leaves the free FIFO holding every id.
                    if (live_cnt > 0)
                    begin
                        n = ($urandom_range(99) < 30) ? live_cnt : $urandom_range(1, live_cnt);
                        repeat (n)
                            issue_rand(OP_DESTROY, any_used_id());
                    end
                end
                2:
                begin
                    // Mixed traffic mostly aimed at live slots.
                    repeat ($urandom_range(20, 80))
                    begin
                        pick = $urandom_range(99);
                        if (pick < 30 || live_cnt == 0)
                            issue_rand(OP_INSERT, $urandom_range(65535));
                        else if (pick < 60)
                            issue_rand(OP_ACCESS, any_used_id());
                        else if (pick < 85)
                            issue_rand(OP_DESTROY, any_used_id());
                        else if (pick < 95)
                        begin
                            op = ($urandom_range(1) == 0) ? OP_ACCESS : OP_DESTROY;
                            issue_rand(op, $urandom_range(SLOTS - 1));
                        end
                        else
                        begin
                            op = ($urandom_range(1) == 0) ? OP_ACCESS : OP_DESTROY;
                            issue_rand(op, $urandom_range(65535));
                        end
                    end
                end
                default:
                begin
                    // Noise: any command code with any id.
                    repeat ($urandom_range(5, 20))
                    begin
                        op = op_t'($urandom_range(3));
                        issue_rand(op, $urandom_range(65535));
                    end
                end
            endcase
            pick = $urandom_range(99);
            if (pick < 20)
                kind = 0;
            else if (pick < 40)
                kind = 1;
            else if (pick < 85)
                kind = 2;
            else
                kind = 3;
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;

        // Wait for every owed response, then keep the clock running so that any
        // stray extra response transfer is caught by the monitor.
        while (table_rsp_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
